// ----- rtl/rwse_pkg.sv -----
// Package: shared types and constants for the register write stream encoder.
package rwse_pkg;

  localparam int unsigned IDX_W   = 8;
  localparam int unsigned VAL_W   = 8;
  localparam int unsigned WORD_W  = 16;
  localparam int unsigned LIMIT_W = 21;
  localparam int unsigned CHUNK_W = 15;

  localparam logic [3:0]         ENV_SHAPE_NIBBLE = 4'hd;
  localparam logic [CHUNK_W-1:0] MAX_CHUNK        = 15'h7fff;
  localparam logic [LIMIT_W-1:0] LIMIT_CAP        = 21'd2064321;
  localparam logic [LIMIT_W-1:0] LIMIT_RESET      = 21'd2064321;

  typedef logic [IDX_W-1:0]   idx_t;
  typedef logic [VAL_W-1:0]   val_t;
  typedef logic [WORD_W-1:0]  word_t;
  typedef logic [LIMIT_W-1:0] limit_t;
  typedef logic [CHUNK_W-1:0] chunk_t;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_LOOK = 3'b010,
    S_EMIT = 3'b100
  } state_e;

endpackage

// ----- rtl/rwse_if.sv -----
// Interfaces: configuration, register write input and command word output channels.
interface rwse_cfg_if
  import rwse_pkg::*;
();
  logic   valid;
  logic   ready;
  limit_t delay_limit;

  modport source (output valid, output delay_limit, input ready);
  modport sink   (input valid, input delay_limit, output ready);
endinterface

interface rwse_evt_if
  import rwse_pkg::*;
#(
  parameter int unsigned TIME_WIDTH = 48
) ();
  logic                  valid;
  logic                  ready;
  logic [TIME_WIDTH-1:0] event_time;
  idx_t                  reg_index;
  val_t                  reg_value;

  modport source (output valid, output event_time, output reg_index, output reg_value,
                  input ready);
  modport sink   (input valid, input event_time, input reg_index, input reg_value,
                  output ready);
endinterface

interface rwse_cmd_if
  import rwse_pkg::*;
();
  logic  valid;
  logic  ready;
  word_t command_word;
  logic  is_last;

  modport source (output valid, output command_word, output is_last, input ready);
  modport sink   (input valid, input command_word, input is_last, output ready);
endinterface

// ----- rtl/register_write_stream_encoder.sv -----
// Top level: register write stream encoder, turns timed register writes into command words.
//
//   port    dir   handshake       payload
//   cfg_i   in    valid/ready     delay_limit
//   evt_i   in    valid/ready     event_time, reg_index, reg_value
//   cmd_o   out   valid/ready     command_word, is_last
//
// A write is accepted in S_IDLE, which also starts the registered value table RAM read;
// S_LOOK compares the read data and a duplicate ends there; a kept write then issues one
// word per cycle in S_EMIT unless the output stalls: delay words, then the write word.
// Reset marks every table entry unwritten through per-entry flags; no clearing pass.
// Output stalls hold the emitter; the input is taken again once the write word is issued.
module register_write_stream_encoder
  import rwse_pkg::*;
#(
  parameter int unsigned REG_COUNT  = 256,
  parameter int unsigned TIME_WIDTH = 48
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  rwse_cfg_if.sink   cfg_i,
  rwse_evt_if.sink   evt_i,
  rwse_cmd_if.source cmd_o
);

  localparam int unsigned AW = $clog2(REG_COUNT);

  state_e                state_q, state_d;
  logic [TIME_WIDTH-1:0] time_q, time_d;
  logic [TIME_WIDTH-1:0] last_time_q, last_time_d;
  idx_t                  idx_q, idx_d;
  val_t                  val_q, val_d;
  limit_t                limit_q, limit_d;
  limit_t                rem_q, rem_d;
  logic [REG_COUNT-1:0]  written_q, written_d;
  logic                  out_valid_q, out_valid_d;
  word_t                 out_word_q, out_word_d;
  logic                  out_last_q, out_last_d;

  logic                  evt_take;
  logic                  load;
  logic                  in_table;
  logic [AW-1:0]         addr;
  logic                  ram_we;
  logic                  ram_re;
  val_t                  ram_rdata;
  logic                  drop;
  logic [TIME_WIDTH-1:0] gap;
  logic                  gap_ok;
  chunk_t                chunk;

  assign cfg_i.ready  = 1'b1;
  assign evt_i.ready  = (state_q == S_IDLE);
  assign evt_take     = evt_i.valid && evt_i.ready;
  assign cmd_o.valid        = out_valid_q;
  assign cmd_o.command_word = out_word_q;
  assign cmd_o.is_last      = out_last_q;

  assign in_table = ({1'b0, idx_q} < (IDX_W + 1)'(REG_COUNT));
  assign addr     = (state_q == S_IDLE) ? evt_i.reg_index[AW-1:0] : idx_q[AW-1:0];
  assign ram_re   = evt_take;
  assign drop     = in_table && (idx_q[3:0] != ENV_SHAPE_NIBBLE) &&
                    written_q[addr] && (ram_rdata == val_q);
  assign ram_we   = (state_q == S_LOOK) && in_table && !drop;

  assign gap    = time_q - last_time_q;
  assign gap_ok = (time_q > last_time_q) && (gap[TIME_WIDTH-1:LIMIT_W] == '0) &&
                  (gap[LIMIT_W-1:0] <= limit_q);
  assign chunk  = (rem_q > limit_t'(MAX_CHUNK)) ? MAX_CHUNK : rem_q[CHUNK_W-1:0];
  assign load   = (state_q == S_EMIT) && (!out_valid_q || cmd_o.ready);

  rwse_ram #(
    .WIDTH (VAL_W),
    .DEPTH (REG_COUNT)
  ) u_value_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (addr),
    .wdata_i (val_q),
    .re_i    (ram_re),
    .raddr_i (addr),
    .rdata_o (ram_rdata)
  );

  always_comb begin
    state_d     = state_q;
    time_d      = time_q;
    last_time_d = last_time_q;
    idx_d       = idx_q;
    val_d       = val_q;
    limit_d     = limit_q;
    rem_d       = rem_q;
    written_d   = written_q;
    out_valid_d = out_valid_q;
    out_word_d  = out_word_q;
    out_last_d  = out_last_q;

    if (cfg_i.valid) begin
      limit_d = (cfg_i.delay_limit > LIMIT_CAP) ? LIMIT_CAP : cfg_i.delay_limit;
    end

    if (cmd_o.ready) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      S_IDLE: begin
        if (evt_take) begin
          time_d  = evt_i.event_time;
          idx_d   = evt_i.reg_index;
          val_d   = evt_i.reg_value;
          state_d = S_LOOK;
        end
      end
      S_LOOK: begin
        if (drop) begin
          state_d = S_IDLE;
        end else begin
          if (in_table) begin
            written_d[addr] = 1'b1;
          end
          rem_d       = gap_ok ? gap[LIMIT_W-1:0] : '0;
          last_time_d = time_q;
          state_d     = S_EMIT;
        end
      end
      S_EMIT: begin
        if (load) begin
          out_valid_d = 1'b1;
          if (rem_q != '0) begin
            out_word_d = {1'b1, chunk};
            out_last_d = 1'b0;
            rem_d      = rem_q - limit_t'(chunk);
          end else begin
            out_word_d = {idx_q, val_q};
            out_last_d = 1'b1;
            state_d    = S_IDLE;
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      last_time_q <= '0;
      limit_q     <= LIMIT_RESET;
      rem_q       <= '0;
      written_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      last_time_q <= last_time_d;
      limit_q     <= limit_d;
      rem_q       <= rem_d;
      written_q   <= written_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    time_q     <= time_d;
    idx_q      <= idx_d;
    val_q      <= val_d;
    out_word_q <= out_word_d;
    out_last_q <= out_last_d;
  end

  a_look_after_take: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_LOOK) |-> $past(evt_take))
    else $error("table compare without a taken write");

  a_no_rw_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(ram_we && ram_re))
    else $error("table read and write in the same cycle");

  a_rem_capped: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rem_q <= LIMIT_CAP)
    else $error("delay remainder above cap");

  a_delay_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_last_q) |-> out_word_q[WORD_W-1])
    else $error("delay word without delay flag");

  a_limit_capped: assert property (@(posedge clk_i) disable iff (!rst_ni)
    limit_q <= LIMIT_CAP)
    else $error("delay limit above cap");

endmodule

// ----- rtl/rwse_ram.sv -----
// Generic single-port-write, single-port-read RAM with registered read data.
module rwse_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- sim/rwse_cmd_checker.sv -----
// Checker: predicts the command words of each accepted register write and compares them.
`timescale 1ns / 1ps

module rwse_cmd_checker
  import rwse_pkg::*;
#(
  parameter int unsigned TIME_W = 48
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_valid_i,
  input  logic              cfg_ready_i,
  input  limit_t            cfg_limit_i,
  input  logic              evt_valid_i,
  input  logic              evt_ready_i,
  input  logic [TIME_W-1:0] evt_time_i,
  input  idx_t              evt_idx_i,
  input  val_t              evt_val_i,
  input  logic              cmd_valid_i,
  input  logic              cmd_ready_i,
  input  word_t             cmd_word_i,
  input  logic              cmd_last_i,
  output int unsigned       mismatch_count_o,
  output int unsigned       words_pending_o
);

  typedef struct packed {
    word_t word;
    logic  last;
  } cmd_t;

  cmd_t              expected_words[$];
  logic [255:0]      reg_written;
  val_t              reg_held[256];
  logic [TIME_W-1:0] last_ticks;
  limit_t            gap_limit;

  task automatic note_mismatch(input string msg);
    mismatch_count_o++;
    if (mismatch_count_o <= 10) begin
      $display("%0t: mismatch: %s", $realtime, msg);
    end
  endtask

  task automatic encode_write(input logic [TIME_W-1:0] ticks, input idx_t idx, input val_t val);
    logic [TIME_W-1:0] gap;
    chunk_t            chunk;
    int                n;
    if (idx[3:0] != ENV_SHAPE_NIBBLE && reg_written[idx] && reg_held[idx] == val) begin
      return;
    end
    reg_written[idx] = 1'b1;
    reg_held[idx]    = val;
    if (ticks > last_ticks) begin
      gap = ticks - last_ticks;
      if (gap <= TIME_W'(gap_limit)) begin
        n = 0;
        while (gap != '0 && n < 63) begin
          chunk = (gap < TIME_W'(MAX_CHUNK)) ? gap[CHUNK_W-1:0] : MAX_CHUNK;
          gap   = gap - TIME_W'(chunk);
          expected_words.push_back('{word: {1'b1, chunk}, last: 1'b0});
          n++;
        end
      end
    end
    last_ticks = ticks;
    expected_words.push_back('{word: {idx, val}, last: 1'b1});
  endtask

  task automatic check_word();
    cmd_t want;
    if (expected_words.size() == 0) begin
      note_mismatch($sformatf("unexpected word %h last %b", cmd_word_i, cmd_last_i));
    end else begin
      want = expected_words.pop_front();
      if (want.word != cmd_word_i) begin
        note_mismatch($sformatf("command_word expected %h, got %h", want.word, cmd_word_i));
      end
      if (want.last != cmd_last_i) begin
        note_mismatch($sformatf("is_last expected %b, got %b", want.last, cmd_last_i));
      end
    end
  endtask

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      expected_words.delete();
      reg_written      = '0;
      last_ticks       = '0;
      gap_limit        = LIMIT_RESET;
      mismatch_count_o = 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        gap_limit = (cfg_limit_i > LIMIT_CAP) ? LIMIT_CAP : cfg_limit_i;
      end
      if (cmd_valid_i && cmd_ready_i) begin
        check_word();
      end
      if (evt_valid_i && evt_ready_i) begin
        encode_write(evt_time_i, evt_idx_i, evt_val_i);
      end
    end
    words_pending_o = expected_words.size();
  end

endmodule

// ----- sim/tb_register_write_stream_encoder.sv -----
// Testbench top: drives register writes and limit settings, and gives the verdict.
`timescale 1ns / 1ps

module tb_register_write_stream_encoder;
  import rwse_pkg::*;

  localparam int unsigned TIME_W = 48;

  logic clk_i = 1'b0;
  logic rst_ni;

  rwse_cfg_if                      cfg_ch ();
  rwse_evt_if #(.TIME_WIDTH(TIME_W)) evt_ch ();
  rwse_cmd_if                      cmd_ch ();

  int unsigned       mismatch_count;
  int unsigned       words_pending;
  int unsigned       hold_requests = 0;
  int unsigned       stall_pct = 0;
  int unsigned       gap_pct = 0;
  logic [TIME_W-1:0] now_ticks;
  idx_t              prev_idx;
  val_t              prev_val;
  limit_t            eff_limit;
  limit_t            lim;

  always #10 clk_i = ~clk_i;

  register_write_stream_encoder #(
    .REG_COUNT (256),
    .TIME_WIDTH(TIME_W)
  ) DUT (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .cfg_i (cfg_ch),
    .evt_i (evt_ch),
    .cmd_o (cmd_ch)
  );

  rwse_cmd_checker #(.TIME_W(TIME_W)) cmd_check (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_valid_i     (cfg_ch.valid),
    .cfg_ready_i     (cfg_ch.ready),
    .cfg_limit_i     (cfg_ch.delay_limit),
    .evt_valid_i     (evt_ch.valid),
    .evt_ready_i     (evt_ch.ready),
    .evt_time_i      (evt_ch.event_time),
    .evt_idx_i       (evt_ch.reg_index),
    .evt_val_i       (evt_ch.reg_value),
    .cmd_valid_i     (cmd_ch.valid),
    .cmd_ready_i     (cmd_ch.ready),
    .cmd_word_i      (cmd_ch.command_word),
    .cmd_last_i      (cmd_ch.is_last),
    .mismatch_count_o(mismatch_count),
    .words_pending_o (words_pending)
  );

  task automatic send_write(input logic [TIME_W-1:0] ticks, input idx_t idx, input val_t val);
    if (gap_pct != 0 && $urandom_range(0, 99) < gap_pct) begin
      evt_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(negedge clk_i);
    end
    evt_ch.valid      <= 1'b1;
    evt_ch.event_time <= ticks;
    evt_ch.reg_index  <= idx;
    evt_ch.reg_value  <= val;
    do @(posedge clk_i); while (!evt_ch.ready);
    @(negedge clk_i);
    now_ticks = ticks;
    prev_idx  = idx;
    prev_val  = val;
  endtask

  task automatic send_random_write();
    int unsigned       pick;
    logic [TIME_W-1:0] ticks;
    idx_t              idx;
    val_t              val;
    pick  = $urandom_range(0, 99);
    ticks = now_ticks;
    if (pick < 45) begin
      ticks = ticks + TIME_W'($urandom_range(1, 300));
    end else if (pick < 60) begin
      ticks = now_ticks;
    end else if (pick < 72) begin
      ticks = ticks + TIME_W'($urandom_range(301, 32'h18000));
    end else if (pick < 77) begin
      ticks = ticks + TIME_W'(eff_limit) + TIME_W'($urandom_range(0, 1));
    end else if (pick < 81) begin
      ticks = ticks + TIME_W'($urandom_range(0, 32'(LIMIT_CAP)));
    end else if (pick < 89) begin
      ticks = ticks - TIME_W'($urandom_range(1, 32'h10000));
    end else if (pick < 95) begin
      ticks = TIME_W'({$urandom, $urandom});
    end else begin
      ticks = ticks + TIME_W'($urandom_range(32'(LIMIT_CAP) + 1, 32'h3fffff));
    end
    if ($urandom_range(0, 99) < 12) begin
      idx = prev_idx;
      val = prev_val;
    end else begin
      idx = idx_t'($urandom_range(0, 255));
      val = val_t'($urandom_range(0, 255));
    end
    send_write(ticks, idx, val);
  endtask

  task automatic write_limit(input limit_t value);
    wait (words_pending == 0);
    @(negedge clk_i);
    repeat (8) @(negedge clk_i);
    cfg_ch.valid       <= 1'b1;
    cfg_ch.delay_limit <= value;
    do @(posedge clk_i); while (!cfg_ch.ready);
    @(negedge clk_i);
    cfg_ch.valid <= 1'b0;
    eff_limit = (value > LIMIT_CAP) ? LIMIT_CAP : value;
  endtask

  initial begin : cmd_sink
    int unsigned stall_left;
    int unsigned hold_left;
    int unsigned holds_served;
    stall_left   = 0;
    hold_left    = 0;
    holds_served = 0;
    cmd_ch.ready <= 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_requests != holds_served) begin
        holds_served = hold_requests;
        hold_left    = 300;
      end
      if (hold_left > 0) begin
        hold_left--;
        cmd_ch.ready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        cmd_ch.ready <= 1'b0;
      end else if (stall_pct != 0 && $urandom_range(0, 99) < stall_pct) begin
        stall_left = $urandom_range(1, 13) - 1;
        cmd_ch.ready <= 1'b0;
      end else begin
        cmd_ch.ready <= 1'b1;
      end
    end
  end

  initial begin
    #40_000_000;
    $display("** register_write_stream_encoder: FAILED **");
    $finish;
  end

  initial begin
    rst_ni             <= 1'b0;
    cfg_ch.valid       <= 1'b0;
    cfg_ch.delay_limit <= '0;
    evt_ch.valid       <= 1'b0;
    evt_ch.event_time  <= '0;
    evt_ch.reg_index   <= '0;
    evt_ch.reg_value   <= '0;
    now_ticks = '0;
    prev_idx  = '0;
    prev_val  = '0;
    eff_limit = LIMIT_RESET;
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    stall_pct = 10;
    gap_pct   = 10;
    send_write(now_ticks, 8'h00, 8'h00);
    send_write(now_ticks, 8'h00, 8'h00);
    send_write(now_ticks + 1, 8'h0d, 8'h10);
    send_write(now_ticks, 8'h0d, 8'h10);
    send_write(now_ticks + TIME_W'(MAX_CHUNK), 8'hff, 8'hff);
    send_write(now_ticks + TIME_W'(32'h8000), 8'h01, 8'h80);
    send_write(now_ticks + TIME_W'(LIMIT_CAP), 8'h10, 8'h55);
    send_write(now_ticks + TIME_W'(LIMIT_CAP) + 1, 8'h20, 8'haa);
    send_write(now_ticks - 5000, 8'h30, 8'h01);
    send_write(now_ticks + 100, 8'h30, 8'h01);
    now_ticks = now_ticks - 100;
    send_write(now_ticks + 250, 8'h30, 8'h02);
    send_write(now_ticks, 8'hfd, 8'hff);
    send_write(now_ticks, 8'hfd, 8'hff);
    send_write('1, 8'h7f, 8'h7f);
    send_write('0, 8'h80, 8'h00);
    send_write(TIME_W'(MAX_CHUNK), 8'h40, 8'h40);
    send_write(now_ticks + TIME_W'(32'h7ffe), 8'h41, 8'h01);
    send_write(now_ticks + 1, 8'h41, 8'h01);
    evt_ch.valid <= 1'b0;

    for (int p = 0; p < 6; p++) begin
      case (p)
        0: begin
          lim = 21'h1fffff;
          stall_pct = 10;
          gap_pct   = 20;
        end
        1: begin
          lim = '0;
          stall_pct = 0;
          gap_pct   = 0;
        end
        2: begin
          lim = limit_t'($urandom_range(1, 32'h1fffff));
          stall_pct = 15;
          gap_pct   = 10;
        end
        3: begin
          lim = 21'h7fff;
          stall_pct = 30;
          gap_pct   = 30;
        end
        4: begin
          lim = 21'd100000;
          stall_pct = 5;
          gap_pct   = 40;
        end
        default: begin
          lim = LIMIT_CAP;
          stall_pct = 0;
          gap_pct   = 0;
        end
      endcase
      write_limit(lim);
      if (p == 2) begin
        hold_requests++;
      end
      repeat (70) send_random_write();
      evt_ch.valid <= 1'b0;
    end

    wait (words_pending == 0);
    repeat (100) @(posedge clk_i);
    if (mismatch_count == 0 && words_pending == 0) begin
      $display("** register_write_stream_encoder: PASSED **");
    end else begin
      $display("** register_write_stream_encoder: FAILED **");
    end
    $finish;
  end

endmodule
